/* rtl/qde_pkg.sv */
// qde_pkg: shared constants, widths and types of the quantizing delta encoder
// no dependencies; used by the interfaces, the divider and the top level

package qde_pkg;

  localparam int unsigned SAMPLE_W = 32;
  localparam int unsigned STEP_W   = 32;
  localparam int unsigned LEVEL_W  = 16;
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned DELTA_W  = LEVEL_W + 1;
  localparam int unsigned DIV_W    = SAMPLE_W + 1;
  localparam int unsigned CNT_W    = $clog2(DIV_W + 1);

  localparam logic [STEP_W-1:0]  STEP_RESET = 32'd65536;
  localparam logic [BYTE_W-1:0]  ESC_CODE   = 8'hFF;
  localparam logic [BYTE_W-1:0]  BYTE_BIAS  = 8'h80;
  localparam logic [LEVEL_W-1:0] LEVEL_BIAS = 16'h8000;
  localparam logic [LEVEL_W-1:0] LEVEL_MAX  = 16'h7FFF;
  localparam logic [LEVEL_W-1:0] LEVEL_MIN  = 16'h8000;
  localparam logic [DIV_W-1:0]   QUOT_MAX   = 33'd32767;
  localparam logic [DIV_W-1:0]   QUOT_MIN   = 33'd32768;
  localparam logic signed [DELTA_W-1:0] DELTA_HI = 17'sd127;
  localparam logic signed [DELTA_W-1:0] DELTA_LO = -17'sd128;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_DIV  = 4'b0010,
    S_ENC  = 4'b0100,
    S_EMIT = 4'b1000
  } qde_state_t;

endpackage

/* rtl/qde_if.sv */
// qde_if: valid/ready channel interfaces for samples, code bytes and step writes
// depends on qde_pkg for payload widths

interface qde_in_if;
  logic                             valid;
  logic                             ready;
  logic signed [qde_pkg::SAMPLE_W-1:0] sample_value;
  logic                             packet_start;
  modport source (output valid, output sample_value, output packet_start, input ready);
  modport sink   (input valid, input sample_value, input packet_start, output ready);
endinterface

interface qde_out_if;
  logic                        valid;
  logic                        ready;
  logic [qde_pkg::BYTE_W-1:0]  code_byte;
  logic                        last_of_sample;
  modport source (output valid, output code_byte, output last_of_sample, input ready);
  modport sink   (input valid, input code_byte, input last_of_sample, output ready);
endinterface

interface qde_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [qde_pkg::STEP_W-1:0]  step_size;
  modport source (output valid, output step_size, input ready);
  modport sink   (input valid, input step_size, output ready);
endinterface

/* rtl/qde_div.sv */
// qde_div: restoring divider, one quotient bit per cycle
// depends on qde_pkg for widths

module qde_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [qde_pkg::DIV_W-1:0]   num,
  input  logic [qde_pkg::DIV_W-1:0]   den,
  output logic                        done,
  output logic [qde_pkg::DIV_W-1:0]   quot
);

  logic [qde_pkg::DIV_W-1:0] rem_r, rem_nxt;
  logic [qde_pkg::DIV_W-1:0] quo_r, quo_nxt;
  logic [qde_pkg::DIV_W-1:0] den_r, den_nxt;
  logic [qde_pkg::CNT_W-1:0] cnt_r, cnt_nxt;
  logic                      done_r, done_nxt;
  logic [qde_pkg::DIV_W:0]   trial;
  logic [qde_pkg::DIV_W:0]   diff;
  logic                      fits;

  assign trial = {rem_r, quo_r[qde_pkg::DIV_W-1]};
  assign diff  = trial - {1'b0, den_r};
  assign fits  = ~diff[qde_pkg::DIV_W];

  always_comb begin
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    den_nxt  = den_r;
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt = '0;
      quo_nxt = num;
      den_nxt = den;
      cnt_nxt = qde_pkg::CNT_W'(qde_pkg::DIV_W);
    end else if (cnt_r != '0) begin
      rem_nxt  = fits ? diff[qde_pkg::DIV_W-1:0] : trial[qde_pkg::DIV_W-1:0];
      quo_nxt  = {quo_r[qde_pkg::DIV_W-2:0], fits};
      cnt_nxt  = cnt_r - qde_pkg::CNT_W'(1);
      done_nxt = (cnt_r == qde_pkg::CNT_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    den_r <= den_nxt;
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
  end

  assign done = done_r;
  assign quot = quo_r;

endmodule

/* rtl/quantized_delta_escape_encoder.sv */
// quantized_delta_escape_encoder: top level, sequencer, level saturation and byte output
// depends on qde_pkg, the channel interfaces in qde_if and the divider qde_div

// Each accepted sample is divided by the step with rounding half away from zero,
// saturated to a signed 16-bit level and sent as one byte (delta + 128) or three
// bytes (0xFF, then level + 32768 high byte first). The sample port is busy while
// a sample with a one-byte code goes through its steps: start the divider, one
// pass of the bit-serial divider per quotient bit, take the quotient, encode and
// load the byte into the output register. An escape code adds a load for each of
// its other bytes. A step of zero skips the divider. The last byte of a sample
// sits in the output register while the next sample is already being divided; an
// output stall longer than that holds the sequencer. Step writes are always taken
// and must only come while idle.

module quantized_delta_escape_encoder (
  input  logic      clk,
  input  logic      rst_n,
  qde_in_if.sink    in_ch,
  qde_out_if.source out_ch,
  qde_cfg_if.sink   cfg_ch
);

  qde_pkg::qde_state_t state_r, state_nxt;

  logic [qde_pkg::STEP_W-1:0]  step_r, step_nxt;
  logic [qde_pkg::LEVEL_W-1:0] prev_r, prev_nxt;
  logic [qde_pkg::LEVEL_W-1:0] level_r, level_nxt;
  logic                        neg_r, neg_nxt;
  logic [qde_pkg::BYTE_W-1:0]  buf_r [3];
  logic [qde_pkg::BYTE_W-1:0]  buf_nxt [3];
  logic [1:0]                  left_r, left_nxt;
  logic                        out_valid_r, out_valid_nxt;
  logic [qde_pkg::BYTE_W-1:0]  out_byte_r, out_byte_nxt;
  logic                        out_last_r, out_last_nxt;

  logic                        in_xfer;
  logic                        in_neg;
  logic [qde_pkg::SAMPLE_W-1:0] in_mag;
  logic [qde_pkg::DIV_W-1:0]   div_num;
  logic [qde_pkg::DIV_W-1:0]   div_den;
  logic                        div_start;
  logic                        div_done;
  logic [qde_pkg::DIV_W-1:0]   div_quot;
  logic                        step_zero;
  logic [qde_pkg::LEVEL_W-1:0] sat_level;
  logic [qde_pkg::LEVEL_W-1:0] zero_level;
  logic signed [qde_pkg::DELTA_W-1:0] delta;
  logic                        esc;
  logic                        out_free;

  assign in_ch.ready  = (state_r == qde_pkg::S_IDLE);
  assign cfg_ch.ready = 1'b1;
  assign in_xfer      = in_ch.valid & in_ch.ready;

  assign in_neg    = in_ch.sample_value[qde_pkg::SAMPLE_W-1];
  assign in_mag    = in_neg ? (~in_ch.sample_value + qde_pkg::SAMPLE_W'(1))
                            : in_ch.sample_value;
  assign div_num   = {in_mag, 1'b0} + {1'b0, step_r};
  assign div_den   = {step_r, 1'b0};
  assign step_zero = (step_r == '0);
  assign div_start = in_xfer & ~step_zero;

  qde_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quot  (div_quot)
  );

  // saturate the rounded quotient and apply the sign
  always_comb begin
    if (neg_r) begin
      sat_level = (div_quot >= qde_pkg::QUOT_MIN) ? qde_pkg::LEVEL_MIN
                  : (~div_quot[qde_pkg::LEVEL_W-1:0] + qde_pkg::LEVEL_W'(1));
    end else begin
      sat_level = (div_quot >= qde_pkg::QUOT_MAX) ? qde_pkg::LEVEL_MAX
                                                 : div_quot[qde_pkg::LEVEL_W-1:0];
    end
  end

  assign zero_level = (in_mag == '0) ? '0 : (in_neg ? qde_pkg::LEVEL_MIN : qde_pkg::LEVEL_MAX);

  assign delta = $signed({level_r[qde_pkg::LEVEL_W-1], level_r})
               - $signed({prev_r[qde_pkg::LEVEL_W-1], prev_r});
  assign esc   = (delta >= qde_pkg::DELTA_HI) || (delta < qde_pkg::DELTA_LO);

  assign out_free = ~out_valid_r | out_ch.ready;

  always_comb begin
    state_nxt     = state_r;
    step_nxt      = step_r;
    prev_nxt      = prev_r;
    level_nxt     = level_r;
    neg_nxt       = neg_r;
    buf_nxt       = buf_r;
    left_nxt      = left_r;
    out_valid_nxt = out_valid_r & ~out_ch.ready;
    out_byte_nxt  = out_byte_r;
    out_last_nxt  = out_last_r;

    if (cfg_ch.valid) begin
      step_nxt = cfg_ch.step_size;
    end

    case (state_r)
      qde_pkg::S_IDLE: begin
        if (in_xfer) begin
          neg_nxt = in_neg;
          if (in_ch.packet_start) begin
            prev_nxt = '0;
          end
          if (step_zero) begin
            level_nxt = zero_level;
            state_nxt = qde_pkg::S_ENC;
          end else begin
            state_nxt = qde_pkg::S_DIV;
          end
        end
      end
      qde_pkg::S_DIV: begin
        if (div_done) begin
          level_nxt = sat_level;
          state_nxt = qde_pkg::S_ENC;
        end
      end
      qde_pkg::S_ENC: begin
        prev_nxt = level_r;
        if (esc) begin
          buf_nxt[0] = qde_pkg::ESC_CODE;
          buf_nxt[1] = level_r[qde_pkg::LEVEL_W-1:qde_pkg::BYTE_W] ^ qde_pkg::LEVEL_BIAS[15:8];
          buf_nxt[2] = level_r[qde_pkg::BYTE_W-1:0];
          left_nxt   = 2'd3;
        end else begin
          buf_nxt[0] = delta[qde_pkg::BYTE_W-1:0] ^ qde_pkg::BYTE_BIAS;
          left_nxt   = 2'd1;
        end
        state_nxt = qde_pkg::S_EMIT;
      end
      qde_pkg::S_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_byte_nxt  = buf_r[0];
          out_last_nxt  = (left_r == 2'd1);
          buf_nxt[0]    = buf_r[1];
          buf_nxt[1]    = buf_r[2];
          left_nxt      = left_r - 2'd1;
          if (left_r == 2'd1) begin
            state_nxt = qde_pkg::S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = qde_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    level_r    <= level_nxt;
    neg_r      <= neg_nxt;
    buf_r      <= buf_nxt;
    out_byte_r <= out_byte_nxt;
    out_last_r <= out_last_nxt;
    if (!rst_n) begin
      state_r     <= qde_pkg::S_IDLE;
      step_r      <= qde_pkg::STEP_RESET;
      prev_r      <= '0;
      left_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      prev_r      <= prev_nxt;
      left_r      <= left_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.code_byte      = out_byte_r;
  assign out_ch.last_of_sample = out_last_r;

`ifndef SYNTH
  // a short code never collides with the escape marker
  a_no_short_esc: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == qde_pkg::S_ENC && !esc) |->
      ((delta[qde_pkg::BYTE_W-1:0] ^ qde_pkg::BYTE_BIAS) != qde_pkg::ESC_CODE))
    else $error("short code equals escape marker");

  // the divider only finishes while the sequencer waits for it
  a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == qde_pkg::S_DIV))
    else $error("divider done outside divide state");

  // no new sample is taken right after one was accepted
  a_busy_after_xfer: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> !in_ch.ready)
    else $error("sample port ready right after a transfer");

  // bytes are only pending while the emitter is active
  a_left_in_emit: assert property (@(posedge clk) disable iff (!rst_n)
    (left_r != 2'd0) |-> (state_r == qde_pkg::S_EMIT))
    else $error("pending bytes outside emit state");
`endif

endmodule
